### design/vdm_pkg.sv
package vdm_pkg;

    localparam int ELEM_W       = 12;
    localparam int ELEM_BITS_DEF = 12;
    localparam int MAX_LEN_DEF  = 1024;

    localparam int IN_W   = 2 * ELEM_W;
    localparam int ACC_W  = 58;
    localparam int ROOT_W = ACC_W / 2;
    localparam int OUT_W  = ((ACC_W + 7) / 8) * 8;
    localparam int MODE_W = 3;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_SUM_SQ    = 3'd0;
    localparam mode_t MODE_MAN_SQ    = 3'd1;
    localparam mode_t MODE_QUAD_ROOT = 3'd2;
    localparam mode_t MODE_MAX_SQ    = 3'd3;
    localparam mode_t MODE_QUAD      = 3'd4;
    localparam mode_t MODE_MAN       = 3'd5;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DRAIN,
        ST_SQUARE,
        ST_SQRT,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic take_item;
        logic do_square;
        logic sqrt_start;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic  fin_ready;
        mode_t fin_mode;
        logic  sqrt_done;
        logic  out_free;
    } dp_status_t;

endpackage

### design/vdm_isqrt.sv
module vdm_isqrt import vdm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [ACC_W-1:0]  operand,
    output logic [ROOT_W-1:0] root,
    output logic              done
);

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ACC_W-1:0]  x_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // bring down the next two bits and try appending a one to the root
    assign rem_shift = {rem_reg[REM_W-3:0], x_reg[ACC_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});
    assign fits      = (rem_shift >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[ACC_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

### design/vdm_datapath.sv
module vdm_datapath import vdm_pkg::*; #(
    parameter int ELEM_BITS = ELEM_BITS_DEF,
    parameter int MAX_LEN   = MAX_LEN_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [IN_W-1:0]  in_data,
    input  logic             in_last,
    input  logic             cfg_we,
    input  mode_t            cfg_mode,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_data,
    output logic             out_sat
);

    localparam int AD_W  = ELEM_BITS;
    localparam int SQ_W  = 2 * AD_W;
    localparam int QD_W  = 4 * AD_W;
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    mode_t mode_reg;

    logic accept;
    assign accept = in_valid && cmd.take_item;

    // element difference and magnitude
    logic [ELEM_BITS-1:0] elem_a;
    logic [ELEM_BITS-1:0] elem_b;
    logic signed [AD_W:0] diff;
    logic [AD_W:0]        mag;

    assign elem_a = in_data[ELEM_BITS-1:0];
    assign elem_b = in_data[ELEM_W + ELEM_BITS - 1 : ELEM_W];
    assign diff   = $signed({elem_b[ELEM_BITS-1], elem_b})
                  - $signed({elem_a[ELEM_BITS-1], elem_a});
    assign mag    = diff[AD_W] ? (AD_W+1)'(-diff) : diff;

    // element count per vector
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             skip_in;

    assign skip_in = (cnt_reg >= CNT_W'(MAX_LEN));

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            priority if (in_last) cnt_next = '0;
            else if (!skip_in)    cnt_next = cnt_reg + 1'b1;
            else                  cnt_next = cnt_reg;
        end
    end

    // stage 1: magnitude, stage 2: square, stage 3: fourth power
    logic v1_reg, v2_reg, v3_reg;
    logic last1_reg, last2_reg, last3_reg;
    logic skip1_reg, skip2_reg, skip3_reg;
    mode_t mode1_reg, mode2_reg, mode3_reg;
    logic [AD_W-1:0] ad1_reg, ad2_reg, ad3_reg;
    logic [SQ_W-1:0] sq2_reg, sq3_reg;
    logic [QD_W-1:0] qd3_reg;

    logic [SQ_W-1:0] sq_prod;
    logic [QD_W-1:0] qd_prod;

    assign sq_prod = ad1_reg * ad1_reg;
    assign qd_prod = sq2_reg * sq2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_SUM_SQ;
            cnt_reg  <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end else begin
            if (cfg_we) mode_reg <= cfg_mode;
            cnt_reg <= cnt_next;
            v1_reg  <= accept;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        last1_reg <= in_last;
        skip1_reg <= skip_in;
        mode1_reg <= mode_reg;
        ad1_reg   <= mag[AD_W-1:0];

        last2_reg <= last1_reg;
        skip2_reg <= skip1_reg;
        mode2_reg <= mode1_reg;
        ad2_reg   <= ad1_reg;
        sq2_reg   <= sq_prod;

        last3_reg <= last2_reg;
        skip3_reg <= skip2_reg;
        mode3_reg <= mode2_reg;
        ad3_reg   <= ad2_reg;
        sq3_reg   <= sq2_reg;
        qd3_reg   <= qd_prod;
    end

    // accumulator
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic             fin_reg, fin_next;
    mode_t            fin_mode_reg;
    logic [ACC_W-1:0] add_val;
    logic [ACC_W:0]   sum;

    always_comb begin
        unique case (mode3_reg)
            MODE_MAN_SQ, MODE_MAN:     add_val = ACC_W'(ad3_reg);
            MODE_QUAD_ROOT, MODE_QUAD: add_val = ACC_W'(qd3_reg);
            MODE_MAX_SQ:               add_val = ACC_W'(ad3_reg);
            default:                   add_val = ACC_W'(sq3_reg);
        endcase
    end

    assign sum = {1'b0, acc_reg} + {1'b0, add_val};

    always_comb begin
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        fin_next = fin_reg;
        priority if (cmd.emit) begin
            acc_next = '0;
            ovf_next = 1'b0;
            fin_next = 1'b0;
        end else if (v3_reg) begin
            if (last3_reg) fin_next = 1'b1;
            priority if (skip3_reg) begin
                ovf_next = 1'b1;
            end else if (mode3_reg == MODE_MAX_SQ) begin
                if (add_val > acc_reg) acc_next = add_val;
            end else if (sum[ACC_W]) begin
                acc_next = ACC_MAX;
                ovf_next = 1'b1;
            end else begin
                acc_next = sum[ACC_W-1:0];
            end
        end else begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            fin_reg <= 1'b0;
        end else begin
            acc_reg <= acc_next;
            ovf_reg <= ovf_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (v3_reg && last3_reg) fin_mode_reg <= mode3_reg;
    end

    // final stage: square or root of the accumulator
    logic [ACC_W-1:0]  res_reg;
    logic              sqov_reg;
    logic [ACC_W-1:0]  acc_square;
    logic [ROOT_W-1:0] root;
    logic              root_done;

    assign acc_square = acc_reg[ROOT_W-1:0] * acc_reg[ROOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.do_square) begin
            res_reg  <= acc_square;
            sqov_reg <= |acc_reg[ACC_W-1:ROOT_W];
        end
    end

    vdm_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .operand (acc_reg),
        .root    (root),
        .done    (root_done)
    );

    // result register
    logic             out_valid_reg;
    logic [ACC_W-1:0] out_dist_reg;
    logic             out_sat_reg;
    logic             squared;
    logic             sat_all;
    logic [ACC_W-1:0] dist_sel;

    assign squared = (fin_mode_reg == MODE_MAN_SQ) || (fin_mode_reg == MODE_MAX_SQ);
    assign sat_all = ovf_reg || (squared && sqov_reg);

    always_comb begin
        priority if (squared)                       dist_sel = res_reg;
        else if (fin_mode_reg == MODE_QUAD_ROOT)    dist_sel = ACC_W'(root);
        else                                        dist_sel = acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            priority if (cmd.emit)  out_valid_reg <= 1'b1;
            else if (out_ready)     out_valid_reg <= 1'b0;
            else                    out_valid_reg <= out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_dist_reg <= sat_all ? ACC_MAX : dist_sel;
            out_sat_reg  <= sat_all;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = OUT_W'(out_dist_reg);
    assign out_sat   = out_sat_reg;

    assign status.fin_ready = fin_reg;
    assign status.fin_mode  = fin_mode_reg;
    assign status.sqrt_done = root_done;
    assign status.out_free  = !out_valid_reg || out_ready;

endmodule

### design/vdm_ctrl.sv
module vdm_ctrl import vdm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       in_last,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_RUN: begin
                cmd.take_item = 1'b1;
                // hold further items until this vector's result is out
                if (in_valid && in_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (status.fin_ready) begin
                    priority if (status.fin_mode == MODE_QUAD_ROOT) begin
                        cmd.sqrt_start = 1'b1;
                        state_next     = ST_SQRT;
                    end else if (status.fin_mode == MODE_MAN_SQ ||
                                 status.fin_mode == MODE_MAX_SQ) begin
                        state_next = ST_SQUARE;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SQUARE: begin
                cmd.do_square = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_SQRT: begin
                if (status.sqrt_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

endmodule

### design/vector_distance_metric_core.sv
// Within a vector one item is taken per cycle through a three-stage multiply pipeline.
// After the last item the input stalls until the result sits in the output register:
// plain sums load the accumulator directly, squared metrics first square it
// (29x29 multiply), and the root metric first runs a 29-step iterative square root.
// Input resumes the cycle after the result is loaded, even if it is not yet taken.
// aresetn is synchronous, active low: clears accumulator, count, flags and sets mode 0.
module vector_distance_metric_core import vdm_pkg::*; #(
    parameter int ELEM_BITS = ELEM_BITS_DEF,
    parameter int MAX_LEN   = MAX_LEN_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // elem_a [11:0], elem_b [23:12]
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // distance [57:0], zero fill [63:58]
    output logic             m_tuser,   // saturated [0]
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  mode_t            cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.take_item;

    vdm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    vdm_datapath #(
        .ELEM_BITS (ELEM_BITS),
        .MAX_LEN   (MAX_LEN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_mode  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_sat   (m_tuser)
    );

    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[ACC_W-1:0] == ACC_MAX)
        else $error("saturated result without full-scale distance");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result loaded over an untaken result");

    a_last_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input not stalled after last item");

    a_root_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sqrt_start |-> status.fin_ready && status.fin_mode == MODE_QUAD_ROOT)
        else $error("square root started outside root metric");

endmodule
